### src/sldsel_pkg.sv
// ----------------------------------------------------------------------------
// sldsel_pkg
// Types and codes for the supply level and duty selector.
// ----------------------------------------------------------------------------
package sldsel_pkg;

  // Word kinds on the input channel
  localparam logic MODE_WRITE   = 1'b0;
  localparam logic MODE_COMPUTE = 1'b1;

  // Duty policies
  localparam logic [1:0] POL_PWM     = 2'd0;
  localparam logic [1:0] POL_NORMAL  = 2'd1;
  localparam logic [1:0] POL_VOLTAGE = 2'd2;

  // Error codes
  localparam logic [1:0] ERR_NONE   = 2'd0;
  localparam logic [1:0] ERR_POWER  = 2'd1;
  localparam logic [1:0] ERR_POLICY = 2'd2;

  // Fixed constants of the selection rules
  localparam logic [15:0] POWER_LIMIT   = 16'd1000;
  localparam logic [3:0]  DEFAULT_LEVEL = 4'd15;
  localparam int          PCT           = 100;
  localparam int          PWM_DIV       = 10;

  // power / 10 as (power * 205) >> 11, exact for power up to 1028
  localparam int          PWM_RECIP     = 205;
  localparam int          PWM_RECIP_SH  = 11;

  // Field widths
  localparam int VOLT_W = 11;
  localparam int DUTY_W = 7;
  localparam int PWR_W  = 10;            // power after the range check
  localparam int PROD_W = 17;            // 100 * (power + 1)
  localparam int QBITS  = 7;             // quotient bits of the serial divider
  localparam int DSH_W  = VOLT_W + QBITS - 1;
  localparam int CMP_W  = 18;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CHECK,
    ST_DIV,
    ST_DONE
  } state_e;

endpackage

### src/supply_level_and_duty_select.sv
// ----------------------------------------------------------------------------
// supply_level_and_duty_select
// Keeps a table of supply voltage levels and picks a level and PWM duty for
// a requested power under one of three policies.
// ----------------------------------------------------------------------------
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid_i/in_ready_o, mode_i,            | input
//          | entry_index_i, entry_centivolts_i,        |
//          | power_permille_i, policy_i                |
//  out     | out_valid_o/out_ready_i, duty_o,          | output
//          | level_index_o, error_code_o               |
//
// A write word is stored on acceptance. A compute word walks the level table
// from the last entry towards entry 0, each entry a registered memory read
// (READ) then a check (CHECK); a qualifying normal level then runs a 7-step
// restoring divider for 100*p/v, while p/10 comes from a reciprocal multiply.
// Pure PWM and error words go straight from IDLE to DONE; normal and pure
// voltage words pass READ and CHECK per entry, normal also DIV. Reset clears
// the per-entry valid bits, so the table reads as all zero with no clearing
// pass. in_ready_o is high in idle even while a result waits in the output
// register; a stalled output holds the walk in its final step.
// ----------------------------------------------------------------------------
module supply_level_and_duty_select #(
  parameter int MAX_DUTY   = 90,
  parameter int NUM_LEVELS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        mode_i,
  input  logic [3:0]  entry_index_i,
  input  logic [10:0] entry_centivolts_i,
  input  logic [15:0] power_permille_i,
  input  logic [1:0]  policy_i,

  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [6:0]  duty_o,
  output logic [3:0]  level_index_o,
  output logic [1:0]  error_code_o
);

  localparam int AW = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
  localparam int VW = sldsel_pkg::VOLT_W;
  localparam int DW = sldsel_pkg::DUTY_W;
  localparam int PW = sldsel_pkg::PROD_W;
  localparam int CW = sldsel_pkg::CMP_W;
  localparam int SW = sldsel_pkg::DSH_W;
  localparam logic [DW-1:0] MAX_D = DW'(MAX_DUTY);
  localparam logic [AW-1:0] LAST  = AW'(NUM_LEVELS - 1);

  // Level table memory with per-entry valid bits
  logic [VW-1:0]         mem [NUM_LEVELS];
  logic [NUM_LEVELS-1:0] vld_q;
  logic [VW-1:0]         rd_data_q;
  logic                  rd_vld_q;

  sldsel_pkg::state_e state_q, state_d;

  logic [AW-1:0]  idx_q, idx_d;
  logic [1:0]     pol_q, pol_d;
  logic [sldsel_pkg::PWR_W-1:0] pwr_q, pwr_d;
  logic [PW-1:0]  pw100_q, pw100_d;
  logic [PW-1:0]  pw100p_q, pw100p_d;
  logic           found_q, found_d;
  logic [PW-1:0]  rem_q, rem_d;
  logic [SW-1:0]  dsh_q, dsh_d;
  logic [2:0]     cnt_q, cnt_d;
  logic [DW-1:0]  quo_q, quo_d;
  logic [DW-1:0]  res_duty_q, res_duty_d;
  logic [3:0]     res_level_q, res_level_d;
  logic [1:0]     res_err_q, res_err_d;

  logic           out_valid_q;
  logic [DW-1:0]  duty_q;
  logic [3:0]     level_q;
  logic [1:0]     err_q;

  logic           in_acc;
  logic           wr_en;
  logic           rd_en;
  logic           load_out;
  logic [VW-1:0]  entry;
  logic           used;
  logic           hit_normal;
  logic           fit_voltage;
  logic [PW-1:0]  pwr_prod;
  logic [PW:0]    trial;
  logic           take;
  logic [DW-1:0]  quo_nxt;
  logic [sldsel_pkg::PWR_W-1:0] tenth_src;
  logic [sldsel_pkg::PWR_W+7:0] tenth_prod;
  logic [DW-1:0]  tenth;
  logic [DW-1:0]  tenth_duty;

  assign in_ready_o = (state_q == sldsel_pkg::ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign wr_en      = in_acc && (mode_i == sldsel_pkg::MODE_WRITE) &&
                      ({1'b0, entry_index_i} < 5'(NUM_LEVELS));
  assign rd_en      = (state_q == sldsel_pkg::ST_READ);

  // Table write and registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[entry_index_i[AW-1:0]] <= entry_centivolts_i;
    end
    if (rd_en) begin
      rd_data_q <= mem[idx_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_q[entry_index_i[AW-1:0]] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_q <= vld_q[idx_q];
      end
    end
  end

  // Entry seen in the check step; an unwritten entry reads as zero
  assign entry = rd_vld_q ? rd_data_q : '0;
  assign used  = (entry != '0);

  // Normal: 100*p/v <= MAX  <=>  100*p < (MAX+1)*v
  assign hit_normal  = (CW'(pw100_q) < CW'(entry) * CW'(MAX_DUTY + 1));
  // Pure voltage: v*MAX/100 <= p  <=>  v*MAX < 100*(p+1)
  assign fit_voltage = (CW'(entry) * CW'(MAX_DUTY) < CW'(pw100p_q));

  assign pwr_prod = PW'(power_permille_i[sldsel_pkg::PWR_W-1:0]) * PW'(sldsel_pkg::PCT);

  // p/10 by reciprocal multiply, clamped to the maximum duty
  assign tenth_src  = (state_q == sldsel_pkg::ST_IDLE) ?
                      power_permille_i[sldsel_pkg::PWR_W-1:0] : pwr_q;
  assign tenth_prod = (sldsel_pkg::PWR_W+8)'(tenth_src) *
                      (sldsel_pkg::PWR_W+8)'(sldsel_pkg::PWM_RECIP);
  assign tenth      = tenth_prod[sldsel_pkg::PWR_W+7:sldsel_pkg::PWM_RECIP_SH];
  assign tenth_duty = (tenth > MAX_D) ? MAX_D : tenth;

  // One restoring divider step
  assign trial   = {1'b0, rem_q} - (PW+1)'(dsh_q);
  assign take    = !trial[PW];
  assign quo_nxt = quo_q | (take ? (DW'(1) << cnt_q) : '0);

  assign load_out = (state_q == sldsel_pkg::ST_DONE) && (!out_valid_q || out_ready_i);

  // Next state and datapath control
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    pol_d       = pol_q;
    pwr_d       = pwr_q;
    pw100_d     = pw100_q;
    pw100p_d    = pw100p_q;
    found_d     = found_q;
    rem_d       = rem_q;
    dsh_d       = dsh_q;
    cnt_d       = cnt_q;
    quo_d       = quo_q;
    res_duty_d  = res_duty_q;
    res_level_d = res_level_q;
    res_err_d   = res_err_q;

    unique case (state_q)
      sldsel_pkg::ST_IDLE: begin
        if (in_acc && (mode_i == sldsel_pkg::MODE_COMPUTE)) begin
          pol_d       = policy_i;
          pwr_d       = power_permille_i[sldsel_pkg::PWR_W-1:0];
          pw100_d     = pwr_prod;
          pw100p_d    = pwr_prod + PW'(sldsel_pkg::PCT);
          idx_d       = LAST;
          found_d     = 1'b0;
          res_err_d   = sldsel_pkg::ERR_NONE;
          res_duty_d  = '0;
          res_level_d = sldsel_pkg::DEFAULT_LEVEL;
          cnt_d       = 3'(sldsel_pkg::QBITS - 1);
          quo_d       = '0;
          if (power_permille_i > sldsel_pkg::POWER_LIMIT) begin
            res_err_d = sldsel_pkg::ERR_POWER;
            state_d   = sldsel_pkg::ST_DONE;
          end else begin
            case (policy_i)
              sldsel_pkg::POL_PWM: begin
                res_level_d = '0;
                res_duty_d  = tenth_duty;
                state_d     = sldsel_pkg::ST_DONE;
              end
              sldsel_pkg::POL_NORMAL: begin
                state_d = sldsel_pkg::ST_READ;
              end
              sldsel_pkg::POL_VOLTAGE: begin
                res_duty_d = MAX_D;
                state_d    = sldsel_pkg::ST_READ;
              end
              default: begin
                res_err_d = sldsel_pkg::ERR_POLICY;
                state_d   = sldsel_pkg::ST_DONE;
              end
            endcase
          end
        end
      end

      sldsel_pkg::ST_READ: begin
        state_d = sldsel_pkg::ST_CHECK;
      end

      sldsel_pkg::ST_CHECK: begin
        if (pol_q == sldsel_pkg::POL_NORMAL) begin
          if (used && hit_normal) begin
            // Qualifying level: duty = 100*p / v
            res_level_d = 4'(idx_q);
            rem_d       = pw100_q;
            dsh_d       = SW'(entry) << (sldsel_pkg::QBITS - 1);
            state_d     = sldsel_pkg::ST_DIV;
          end else if (idx_q == '0) begin
            // No level qualifies: fall back to level 0, duty p/10
            res_level_d = '0;
            res_duty_d  = tenth_duty;
            state_d     = sldsel_pkg::ST_DONE;
          end else begin
            idx_d   = idx_q - AW'(1);
            state_d = sldsel_pkg::ST_READ;
          end
        end else begin
          // Pure voltage walk
          if (used && !fit_voltage) begin
            if (!found_q) begin
              res_level_d = 4'(idx_q);
              res_duty_d  = '0;
            end
            state_d = sldsel_pkg::ST_DONE;
          end else begin
            if (used) begin
              found_d     = 1'b1;
              res_level_d = 4'(idx_q);
            end
            if (idx_q == '0) begin
              state_d = sldsel_pkg::ST_DONE;
            end else begin
              idx_d   = idx_q - AW'(1);
              state_d = sldsel_pkg::ST_READ;
            end
          end
        end
      end

      sldsel_pkg::ST_DIV: begin
        if (take) begin
          rem_d = trial[PW-1:0];
        end
        quo_d = quo_nxt;
        dsh_d = dsh_q >> 1;
        cnt_d = cnt_q - 3'd1;
        if (cnt_q == '0) begin
          res_duty_d = (quo_nxt > MAX_D) ? MAX_D : quo_nxt;
          state_d    = sldsel_pkg::ST_DONE;
        end
      end

      sldsel_pkg::ST_DONE: begin
        if (load_out) begin
          state_d = sldsel_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = sldsel_pkg::ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sldsel_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    idx_q       <= idx_d;
    pol_q       <= pol_d;
    pwr_q       <= pwr_d;
    pw100_q     <= pw100_d;
    pw100p_q    <= pw100p_d;
    found_q     <= found_d;
    rem_q       <= rem_d;
    dsh_q       <= dsh_d;
    cnt_q       <= cnt_d;
    quo_q       <= quo_d;
    res_duty_q  <= res_duty_d;
    res_level_q <= res_level_d;
    res_err_q   <= res_err_d;
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      duty_q  <= res_duty_q;
      level_q <= res_level_q;
      err_q   <= res_err_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign duty_o        = duty_q;
  assign level_index_o = level_q;
  assign error_code_o  = err_q;

endmodule
